/* design/iirdf1_pkg.sv */
// Shared types and constants for the direct form I IIR filter.
// No dependencies; imported by every module of the block.
package iirdf1_pkg;

   // default tap counts and the size of each coefficient bank
   localparam int NUM_TAPS_DEF = 3;
   localparam int DEN_TAPS_DEF = 3;
   localparam int NUM_COEF     = 3;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 32;
   localparam int OUT_W      = 32;
   localparam int STAT_W     = 2;
   localparam int PROD_W     = 64;
   localparam int ACC_W      = 66;
   localparam int MAG_W      = 64;
   localparam int QUO_W      = 33;
   localparam int CNT_W      = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_A0 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_A1 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_A2 = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_SAT     = 2'd1;
   localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd2;

   localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd268435456;
   localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;
   localparam logic [QUO_W-1:0] NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [CNT_W-1:0] DIV_STEPS = 6'd33;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
      logic neg;
      logic shift8;
   } mac_ctl_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OUT_W-1:0]  value;
   } div_res_type;

endpackage

/* design/iirdf1_mac.sv */
// Shared 32x32 multiplier with registered product and 66-bit accumulator.
// Depends on iirdf1_pkg.
module iirdf1_mac (
   input  logic                                      clock,
   input  iirdf1_pkg::mac_ctl_type                   ctl,
   input  logic signed [iirdf1_pkg::COEF_W-1:0]      op_a,
   input  logic signed [iirdf1_pkg::COEF_W-1:0]      op_b,
   output logic signed [iirdf1_pkg::ACC_W-1:0]       acc
);
   import iirdf1_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic                     shift_ff, shift_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  term_ext, term;

   always_comb begin
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      if (ctl.mul_en) begin
         prod_in  = PROD_W'(op_a) * PROD_W'(op_b);
         neg_in   = ctl.neg;
         shift_in = ctl.shift8;
      end
      term_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      // numerator products go from Q.28 to Q.36
      term     = shift_ff ? (term_ext <<< 8) : term_ext;
      acc_in   = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = neg_ff ? (acc_ff - term) : (acc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* design/iirdf1_div.sv */
// Radix-2 restoring divider with overflow shortcut, sign handling and
// 32-bit saturation. Depends on iirdf1_pkg.
module iirdf1_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  ack,
   input  logic signed [iirdf1_pkg::ACC_W-1:0]   num,
   input  logic signed [iirdf1_pkg::COEF_W-1:0]  den,
   output logic                                  valid,
   output iirdf1_pkg::div_res_type               res
);
   import iirdf1_pkg::*;

   typedef enum logic [4:0] {
      D_IDLE = 5'b00001,
      D_CHK  = 5'b00010,
      D_RUN  = 5'b00100,
      D_FIN  = 5'b01000,
      D_HOLD = 5'b10000
   } dstate_type;

   dstate_type        state_ff, state_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [COEF_W-1:0] dmag_ff, dmag_in;
   logic [COEF_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   div_res_type       res_ff, res_in;

   logic signed [ACC_W-1:0] num_abs;
   logic [COEF_W:0]         den_abs;
   logic [COEF_W:0]         trial, diff;
   logic                    ge;

   always_comb begin
      num_abs = num[ACC_W-1] ? -num : num;
      den_abs = den[COEF_W-1] ? -{den[COEF_W-1], den} : {den[COEF_W-1], den};
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = trial - {1'b0, dmag_ff};
      ge      = trial >= {1'b0, dmag_ff};

      state_in = state_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      mag_in   = mag_ff;
      dmag_in  = dmag_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;

      case (state_ff)
         D_IDLE: begin
            if (start) begin
               neg_in   = num[ACC_W-1] ^ den[COEF_W-1];
               zero_in  = (den == '0);
               mag_in   = num_abs[MAG_W-1:0];
               dmag_in  = den_abs[COEF_W-1:0];
               state_in = D_CHK;
            end
         end
         D_CHK: begin
            if (zero_ff) begin
               res_in   = '{status: ST_DIVZERO, value: '0};
               state_in = D_HOLD;
            end else if ({1'b0, mag_ff[MAG_W-1:QUO_W]} >= dmag_ff) begin
               // quotient is at least 2^33: saturate without iterating
               res_in   = '{status: ST_SAT, value: (neg_ff ? OUT_MIN : OUT_MAX)};
               state_in = D_HOLD;
            end else begin
               rem_in   = {1'b0, mag_ff[MAG_W-1:QUO_W]};
               quo_in   = mag_ff[QUO_W-1:0];
               cnt_in   = DIV_STEPS;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = ge ? diff[COEF_W-1:0] : trial[COEF_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (neg_ff) begin
               if (quo_ff > NEG_LIMIT) begin
                  res_in = '{status: ST_SAT, value: OUT_MIN};
               end else begin
                  res_in = '{status: ST_OK, value: -quo_ff[OUT_W-1:0]};
               end
            end else begin
               if (quo_ff[QUO_W-1] | quo_ff[QUO_W-2]) begin
                  res_in = '{status: ST_SAT, value: OUT_MAX};
               end else begin
                  res_in = '{status: ST_OK, value: quo_ff[OUT_W-1:0]};
               end
            end
            state_in = D_HOLD;
         end
         D_HOLD: begin
            if (ack) begin
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      mag_ff  <= mag_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign valid = (state_ff == D_HOLD);
   assign res   = res_ff;

endmodule

/* design/iir_direct_form_one_filter.sv */
// Direct form I IIR filter top level: sequencer, coefficient and history
// registers, output register. Depends on iirdf1_pkg, iirdf1_mac, iirdf1_div.
//
// Usage:
//   req_*  : one beat carries one signed 16-bit integer sample.
//   rsp_*  : one beat per sample: 32-bit Q.8 result plus 2-bit status
//            (ok, saturated, divisor zero).
//   csr_*  : write-only coefficient port, taken on any edge with csr_wen;
//            write only while the filter is idle. Indexes above 5 are ignored.
// Sequence:
//   One shared multiplier takes a multiply and an accumulate step per tap,
//   then a radix-2 divider runs 33 steps; the defaults give three numerator
//   and two feedback taps. A quotient of 2^33 or more, or a zero divisor,
//   skips the divide steps. req_tready is high only while the sequencer is
//   idle.
// Reset clears the sample and output history, loads b0 = a0 = 1.0 and the
// other coefficients with 0, and empties the output register.
// A stalled receiver: the result sits in the output register while the
// next sample is accepted and computed; that sample's result waits in the
// divider until the register frees up.
module iir_direct_form_one_filter #(
   parameter int NUM_TAPS = iirdf1_pkg::NUM_TAPS_DEF,
   parameter int DEN_TAPS = iirdf1_pkg::DEN_TAPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [iirdf1_pkg::REQ_DATA_W-1:0]      req_tdata,   // [15:0] sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [iirdf1_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [31:0] filtered_out,
                                                               // [33:32] status, pad
   input  logic                                   csr_wen,
   input  logic [iirdf1_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [iirdf1_pkg::COEF_W-1:0]          csr_wdata
);
   import iirdf1_pkg::*;

   // taps actually used: limited by the coefficient banks
   localparam int NT     = (NUM_TAPS > NUM_COEF) ? NUM_COEF : NUM_TAPS;
   localparam int DT     = (DEN_TAPS - 1 > NUM_COEF - 1) ? NUM_COEF - 1 : DEN_TAPS - 1;
   localparam int TOTAL  = NT + DT;
   localparam int TAP_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TOTAL - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_ACC   = 5'b00100,
      S_START = 5'b01000,
      S_DIV   = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [TAP_W-1:0]           tap_ff, tap_in;
   logic signed [SAMPLE_W-1:0] x_cur_ff, x_cur_in;
   logic signed [SAMPLE_W-1:0] xh_ff [2];
   logic signed [SAMPLE_W-1:0] xh_in [2];
   logic signed [OUT_W-1:0]    yh_ff [2];
   logic signed [OUT_W-1:0]    yh_in [2];
   logic signed [COEF_W-1:0]   coef_b_ff [NUM_COEF];
   logic signed [COEF_W-1:0]   coef_b_in [NUM_COEF];
   logic signed [COEF_W-1:0]   coef_a_ff [NUM_COEF];
   logic signed [COEF_W-1:0]   coef_a_in [NUM_COEF];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                       accept, rsp_free, load;
   logic [2:0]                 tap3, den_off;
   logic [1:0]                 num_idx;
   logic                       is_fb;
   logic signed [SAMPLE_W-1:0] x_sel;
   logic signed [COEF_W-1:0]   b_sel, a_sel, y_sel;
   logic signed [COEF_W-1:0]   op_a, op_b;
   mac_ctl_type                mac_ctl;
   logic signed [ACC_W-1:0]    acc;
   logic                       div_valid;
   div_res_type                div_res;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign load       = (state_ff == S_DIV) & div_valid & rsp_free;

   // operand select for the current tap: numerator taps first, then feedback
   always_comb begin
      tap3    = 3'(tap_ff);
      is_fb   = (tap3 >= 3'(NT));
      den_off = tap3 - 3'(NT);
      num_idx = tap3[1:0];
      case (num_idx)
         2'd0: begin
            x_sel = x_cur_ff;
            b_sel = coef_b_ff[0];
         end
         2'd1: begin
            x_sel = xh_ff[0];
            b_sel = coef_b_ff[1];
         end
         default: begin
            x_sel = xh_ff[1];
            b_sel = coef_b_ff[2];
         end
      endcase
      y_sel = yh_ff[den_off[0]];
      a_sel = den_off[0] ? coef_a_ff[2] : coef_a_ff[1];
      op_a  = is_fb ? y_sel : {{(COEF_W-SAMPLE_W){x_sel[SAMPLE_W-1]}}, x_sel};
      op_b  = is_fb ? a_sel : b_sel;

      mac_ctl.clear  = accept;
      mac_ctl.mul_en = (state_ff == S_MUL);
      mac_ctl.acc_en = (state_ff == S_ACC);
      mac_ctl.neg    = is_fb;
      mac_ctl.shift8 = ~is_fb;
   end

   // sequencer, history, coefficients, output register
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      x_cur_in     = x_cur_ff;
      xh_in        = xh_ff;
      yh_in        = yh_ff;
      coef_b_in    = coef_b_ff;
      coef_a_in    = coef_a_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff & rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_cur_in = req_tdata[SAMPLE_W-1:0];
               tap_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (tap_ff == LAST_TAP) begin
               state_in = S_START;
            end else begin
               tap_in   = tap_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (load) begin
               xh_in[1]     = xh_ff[0];
               xh_in[0]     = x_cur_ff;
               yh_in[1]     = yh_ff[0];
               yh_in[0]     = div_res.value;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-OUT_W-STAT_W){1'b0}},
                               div_res.status, div_res.value};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wen) begin
         case (csr_addr)
            REG_B0:  coef_b_in[0] = csr_wdata;
            REG_B1:  coef_b_in[1] = csr_wdata;
            REG_B2:  coef_b_in[2] = csr_wdata;
            REG_A0:  coef_a_in[0] = csr_wdata;
            REG_A1:  coef_a_in[1] = csr_wdata;
            REG_A2:  coef_a_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         xh_ff        <= '{default: '0};
         yh_ff        <= '{default: '0};
         coef_b_ff    <= '{COEF_ONE, '0, '0};
         coef_a_ff    <= '{COEF_ONE, '0, '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         xh_ff        <= xh_in;
         yh_ff        <= yh_in;
         coef_b_ff    <= coef_b_in;
         coef_a_ff    <= coef_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tap_ff      <= tap_in;
      x_cur_ff    <= x_cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   iirdf1_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   iirdf1_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_START),
      .ack   (load),
      .num   (acc),
      .den   (coef_a_ff[0]),
      .valid (div_valid),
      .res   (div_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a saturated beat carries one of the two bounds
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[OUT_W+STAT_W-1:OUT_W] == ST_SAT) |->
      (rsp_tdata[OUT_W-1:0] == OUT_MAX || rsp_tdata[OUT_W-1:0] == OUT_MIN))
      else $error("saturated beat without a bound value");

   // zero divisor gives a zero result
   a_divzero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[OUT_W+STAT_W-1:OUT_W] == ST_DIVZERO) |->
      (rsp_tdata[OUT_W-1:0] == '0))
      else $error("zero-divisor beat with nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[OUT_W+STAT_W-1:OUT_W] == ST_OK ||
                      rsp_tdata[OUT_W+STAT_W-1:OUT_W] == ST_SAT ||
                      rsp_tdata[OUT_W+STAT_W-1:OUT_W] == ST_DIVZERO))
      else $error("undefined status code");

   // an accepted sample keeps the input side closed while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input reopened right after accept");

   // a result is handed over only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("result loaded but output register not valid");

endmodule

/* sim/tb_top.sv */
// Self-checking bench for the direct form I IIR filter: a directed table, then
// randomized coefficient phases, every result beat checked against a typed-in value or a bit-exact predictor.
// Depends on iirdf1_pkg and iir_direct_form_one_filter.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iirdf1_pkg::*;

   // run shape
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 112;
   localparam int IDLE_GUARD     = 4;     // cycles after the last beat before a CSR write
   localparam int TAIL_CYCLES    = 64;    // one sample's worth of latency, plus margin
   localparam int HOLDOFF_CYCLES = 500;   // long enough to back the block up
   localparam int RESET_CYCLES   = 9;

   // indexes past the coefficient bank, which the block must ignore
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

   typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {COEF_STABLE, COEF_WILD, COEF_HOT, COEF_NODIV} coef_style_type;

   typedef struct packed {
      logic [OUT_W-1:0]  value;
      logic [STAT_W-1:0] status;
   } filt_result_type;

   // one line of the directed table: either a CSR write or a sample beat,
   // with the result typed in where it is obvious
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [COEF_W-1:0]     wdata;
      logic [SAMPLE_W-1:0]   sample;
      logic                  known;
      filt_result_type       result;
   } stim_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [15:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [31:0] filtered_out, [33:32] status, pad
   logic                  csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [COEF_W-1:0]     csr_wdata  = '0;

   // predictor state: coefficient bank and the two delay lines
   logic signed [COEF_W-1:0]   tap_b [NUM_COEF];
   logic signed [COEF_W-1:0]   tap_a [NUM_COEF];
   logic signed [SAMPLE_W-1:0] x_delay [2];
   logic signed [OUT_W-1:0]    y_delay [2];

   filt_result_type pending_outputs [$];   // oldest first
   stim_row_type    directed_rows [$];
   filt_result_type want;
   int              mismatch_count  = 0;
   int              sender_idle_pct = 0;
   int              rsp_stall_pct   = 0;
   int              rsp_holdoff     = 0;   // counted down by the receiver process

   iir_direct_form_one_filter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void reset_predictor();
      foreach (tap_b[k]) begin
         tap_b[k] = '0;
         tap_a[k] = '0;
      end
      tap_b[0] = COEF_ONE;
      tap_a[0] = COEF_ONE;
      foreach (x_delay[k]) begin
         x_delay[k] = '0;
         y_delay[k] = '0;
      end
   endfunction

   function automatic void store_coef(logic [CSR_ADDR_W-1:0] addr, logic [COEF_W-1:0] value);
      if (addr <= REG_B2) tap_b[addr - REG_B0] = value;
      else if (addr <= REG_A2) tap_a[addr - REG_A0] = value;
   endfunction

   // One filter step. The numerator taps are Q.28, shifted up to Q.36 to line
   // up with the feedback products. 72 bits hold the sum exactly, so the
   // divide and the clamp below see the true value.
   function automatic filt_result_type filter_step(logic signed [SAMPLE_W-1:0] x);
      logic signed [SAMPLE_W-1:0] taps_x [NUM_COEF];
      logic signed [71:0]         acc;
      logic signed [71:0]         lhs;
      logic signed [71:0]         rhs;
      logic [71:0]                mag;
      logic [71:0]                dmag;
      logic [71:0]                quo;
      logic                       neg;
      filt_result_type            res;
      int                         num_used;
      int                         fb_used;

      num_used  = (NUM_TAPS_DEF > NUM_COEF) ? NUM_COEF : NUM_TAPS_DEF;
      fb_used   = (DEN_TAPS_DEF > NUM_COEF) ? NUM_COEF - 1 : DEN_TAPS_DEF - 1;
      taps_x[0] = x;
      taps_x[1] = x_delay[0];
      taps_x[2] = x_delay[1];
      acc = '0;
      for (int k = 0; k < num_used; k++) begin
         lhs = taps_x[k];
         rhs = tap_b[k];
         acc = acc + ((lhs * rhs) <<< 8);
      end
      for (int k = 0; k < fb_used; k++) begin
         lhs = y_delay[k];
         rhs = tap_a[k + 1];
         acc = acc - lhs * rhs;
      end

      res.status = ST_OK;
      if (tap_a[0] == 0) begin
         res.value  = '0;
         res.status = ST_DIVZERO;
      end else begin
         // sign-magnitude divide, truncating toward zero
         rhs  = tap_a[0];
         mag  = acc[71] ? -acc : acc;
         dmag = rhs[71] ? -rhs : rhs;
         quo  = mag / dmag;
         neg  = acc[71] ^ rhs[71];
         if (neg) begin
            if (quo > 72'h8000_0000) begin
               res.value  = OUT_MIN;
               res.status = ST_SAT;
            end else begin
               res.value = 32'(72'd0 - quo);
            end
         end else if (quo > 72'h7FFF_FFFF) begin
            res.value  = OUT_MAX;
            res.status = ST_SAT;
         end else begin
            res.value = quo[OUT_W-1:0];
         end
      end

      // history moves on in every case, divisor zero included
      x_delay[1] = x_delay[0];
      x_delay[0] = x;
      y_delay[1] = y_delay[0];
      y_delay[0] = res.value;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table builders
   // ---------------------------------------------------------------------
   function automatic void put_cfg(logic [CSR_ADDR_W-1:0] addr, logic [COEF_W-1:0] value);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_CFG;
      row.addr  = addr;
      row.wdata = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void put_known(logic [SAMPLE_W-1:0] s, logic [OUT_W-1:0] value,
                                     logic [STAT_W-1:0] status);
      stim_row_type row;
      row               = '0;
      row.kind          = ROW_SAMPLE;
      row.sample        = s;
      row.known         = 1'b1;
      row.result.value  = value;
      row.result.status = status;
      directed_rows.push_back(row);
   endfunction

   function automatic void put_smp(logic [SAMPLE_W-1:0] s);
      stim_row_type row;
      row        = '0;
      row.kind   = ROW_SAMPLE;
      row.sample = s;
      directed_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // Random value helpers
   // ---------------------------------------------------------------------
   // signed value spread evenly over +/- 2^(bits-1)
   function automatic logic [COEF_W-1:0] rand_coef(int bits);
      return COEF_W'(int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
   endfunction

   // mostly full range, some small values, some rails
   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return SAMPLE_W'($urandom);
      if (pick < 85) return SAMPLE_W'($urandom_range(0, 510) - 255);
      case ($urandom_range(3))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Drivers. Everything is driven with NBAs right after a rising edge.
   // ---------------------------------------------------------------------
   // caller drops csr_wen after the last write of a burst
   task automatic write_coef(logic [CSR_ADDR_W-1:0] addr, logic [COEF_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      store_coef(addr, value);
   endtask

   // Offers one sample beat and records what should come back. tvalid is left
   // high after the accept so back-to-back beats never toggle it within a step.
   task automatic send_sample(logic [SAMPLE_W-1:0] s, logic known,
                              filt_result_type known_res);
      filt_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      predicted = filter_step(s);
      pending_outputs.push_back(known ? known_res : predicted);
   endtask

   // stop offering and wait for every outstanding result beat
   task automatic drain_filter();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   task automatic load_phase_coefs(coef_style_type style);
      logic [COEF_W-1:0] c [NUM_COEF * 2];
      case (style)
         COEF_STABLE: begin
            // |a1| < 0.5, |a2| < 0.25, a0 in [1, 2]: poles inside the unit circle
            c[REG_B0] = rand_coef(28);
            c[REG_B1] = rand_coef(28);
            c[REG_B2] = rand_coef(28);
            c[REG_A0] = COEF_ONE + COEF_W'($urandom_range(0, 1 << 28));
            c[REG_A1] = rand_coef(28);
            c[REG_A2] = rand_coef(27);
         end
         COEF_HOT: begin
            // tiny divisor: saturates often and feeds the rails back
            c[REG_B0] = rand_coef(29);
            c[REG_B1] = rand_coef(29);
            c[REG_B2] = rand_coef(29);
            c[REG_A0] = $urandom_range(1) ? COEF_W'($urandom_range(1, 4095))
                                          : -COEF_W'($urandom_range(1, 4095));
            c[REG_A1] = rand_coef(29);
            c[REG_A2] = rand_coef(29);
         end
         default: begin
            foreach (c[r]) c[r] = $urandom;
            if (style == COEF_NODIV) c[REG_A0] = '0;
         end
      endcase
      for (int r = REG_B0; r <= REG_A2; r++) write_coef(CSR_ADDR_W'(r), c[r]);
      // a stray write past the bank must change nothing
      write_coef($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      csr_wen <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_holdoff > 0) begin
            rsp_holdoff = rsp_holdoff - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted beat against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            $error("result beat with nothing pending: filtered_out %0d status %0d",
                   $signed(rsp_tdata[OUT_W-1:0]), rsp_tdata[OUT_W +: STAT_W]);
            mismatch_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want.value) begin
               $error("filtered_out: expected %0d, got %0d",
                      $signed(want.value), $signed(rsp_tdata[OUT_W-1:0]));
               mismatch_count++;
            end
            if (rsp_tdata[OUT_W +: STAT_W] !== want.status) begin
               $error("status: expected %0d, got %0d",
                      want.status, rsp_tdata[OUT_W +: STAT_W]);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      filt_result_type no_result;
      coef_style_type  style;

      no_result = '0;
      reset_predictor();

      // After reset b0 = a0 = 1.0, so y is the sample in Q.8.
      put_known(16'h0000, 32'd0, ST_OK);
      put_known(16'h7FFF, 32'd8388352, ST_OK);
      put_known(16'h8000, 32'hFF80_0000, ST_OK);
      put_known(16'h0001, 32'd256, ST_OK);
      // a0 = 3.0: 256/3 truncates toward zero on both signs
      put_cfg(REG_A0, 32'h3000_0000);
      put_known(16'h0001, 32'd85, ST_OK);
      put_known(16'hFFFF, 32'hFFFF_FFAB, ST_OK);
      // divisor zero: result 0 regardless of input
      put_cfg(REG_A0, 32'h0000_0000);
      put_known(16'd100, 32'd0, ST_DIVZERO);
      put_known(16'h8000, 32'd0, ST_DIVZERO);
      // a0 = 1 lsb, b0 = 2^23: x = -1 lands exactly on the low rail, no clamp
      put_cfg(REG_A0, 32'h0000_0001);
      put_cfg(REG_B0, 32'h0080_0000);
      put_known(16'hFFFF, OUT_MIN, ST_OK);
      put_known(16'h0001, OUT_MAX, ST_SAT);
      put_known(16'hFFFE, OUT_MIN, ST_SAT);
      // negative divisor flips the sign and the rail
      put_cfg(REG_A0, 32'hFFFF_FFFF);
      put_known(16'h0001, OUT_MIN, ST_OK);
      put_known(16'hFFFF, OUT_MAX, ST_SAT);
      // writes past the bank are dropped
      put_cfg(REG_SPARE_LO, 32'hFFFF_FFFF);
      put_cfg(REG_SPARE_HI, 32'h0000_0000);
      put_known(16'h0001, OUT_MIN, ST_OK);
      // every coefficient at a rail, rails on the input too
      put_cfg(REG_B0, 32'h8000_0000);
      put_cfg(REG_B1, 32'h8000_0000);
      put_cfg(REG_B2, 32'h7FFF_FFFF);
      put_cfg(REG_A0, 32'h8000_0000);
      put_cfg(REG_A1, 32'h8000_0000);
      put_cfg(REG_A2, 32'h7FFF_FFFF);
      put_smp(16'h8000);
      put_smp(16'h7FFF);
      put_smp(16'h8000);
      put_smp(16'h7FFF);
      put_cfg(REG_A0, 32'h7FFF_FFFF);
      put_smp(16'h7FFF);
      put_smp(16'h8000);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table; CSR writes only once the filter has gone quiet
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            if (i == 0 || directed_rows[i - 1].kind == ROW_SAMPLE) drain_filter();
            write_coef(directed_rows[i].addr, directed_rows[i].wdata);
            if (i == directed_rows.size() - 1 || directed_rows[i + 1].kind != ROW_CFG)
               csr_wen <= 1'b0;
         end else begin
            send_sample(directed_rows[i].sample, directed_rows[i].known,
                        directed_rows[i].result);
         end
      end

      // Random phases: each gets a fresh coefficient set and its own
      // flow-control mix (none, sender gaps, receiver stalls, light both).
      for (int p = 0; p < PHASES; p++) begin
         drain_filter();
         case (p)
            2, 8:    style = COEF_WILD;
            4, 10:   style = COEF_HOT;
            5:       style = COEF_NODIV;
            default: style = COEF_STABLE;
         endcase
         load_phase_coefs(style);
         case (p % 4)
            0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin sender_idle_pct = 85; rsp_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rsp_stall_pct = 85; end
            default: begin sender_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // receiver goes quiet while beats keep coming: output register and
            // divider fill, and req_tready has to drop
            if (p == 6 && n == 30) rsp_holdoff = HOLDOFF_CYCLES;
            // sender stops mid-phase until the pipe is empty
            if (p == 7 && n == 50) drain_filter();
            send_sample(rand_sample(), 1'b0, no_result);
         end
      end

      drain_filter();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("iir_direct_form_one_filter verification clean");
      else
         $display("iir_direct_form_one_filter verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("iir_direct_form_one_filter verification failed");
      $finish;
   end

endmodule
